/* hdl/lltd_pkg.sv */
// ----------------------------------------------------------------------------
// lltd_pkg
// Shared widths, defaults and field layout for the least-loaded dispatcher.
// ----------------------------------------------------------------------------
package lltd_pkg;

   localparam int DEF_MAX_WORKERS = 16;
   localparam int DEF_MAX_TASKS   = 1024;

   localparam int LOAD_W = 32;
   localparam int TIME_W = 16;
   localparam int WC_W   = 5;

   localparam logic [WC_W-1:0] WC_RESET = 5'd16;

   localparam int WORKER_W  = 4;
   localparam int TASKNUM_W = 11;
   localparam int SLOT_W    = 10;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;

endpackage

/* hdl/least_loaded_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher
// Greedy list scheduler: assigns each task to the least loaded worker.
// ----------------------------------------------------------------------------
//  group   dir  signals                      contents
//  req     in   tvalid/tready/tdata/tuser    task_time; tuser = first_task
//  rsp     out  tvalid/tready/tdata          worker, task no, slot, new load
//  csr     in   wr_en/wr_data                worker_count
//
//  For each word the scan word walks the cell chain one worker per cycle;
//  then the minimum is captured and the update is committed.
//  Reset clears all loads, counts and the task number; worker_count = 16.
//  A new word is taken while the previous result waits in the output register;
//  the commit waits for that register to drain.
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher #(
   parameter int MAX_WORKERS = lltd_pkg::DEF_MAX_WORKERS,
   parameter int MAX_TASKS   = lltd_pkg::DEF_MAX_TASKS
) (
   input  logic                                clock,
   input  logic                                reset,
   // task_time [15:0]
   input  logic [lltd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first_task [0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // assigned_worker [3:0], task_number [14:4], slot_in_worker [24:15],
   // worker_load_after [56:25], zero [63:57]
   output logic [lltd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [lltd_pkg::WC_W-1:0]           csr_wr_data
);

   localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int NW    = $clog2(MAX_WORKERS + 1);
   localparam int LW    = lltd_pkg::LOAD_W;
   localparam int PAD_W = lltd_pkg::RSP_DATA_W - lltd_pkg::WORKER_W
                          - lltd_pkg::TASKNUM_W - lltd_pkg::SLOT_W - LW;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [LW-1:0]    load;
      logic [CNT_W-1:0] cnt;
   } token_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [LW-1:0]    load;
      logic [CNT_W-1:0] cnt;
   } update_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type                       state_ff;
   logic [lltd_pkg::WC_W-1:0]       wc_ff;
   logic [lltd_pkg::TIME_W-1:0]     time_ff;
   logic                            start_ff;
   logic [CNT_W-1:0]                seen_ff, seen_in;
   logic [IDX_W-1:0]                best_idx_ff;
   logic [LW-1:0]                   best_load_ff;
   logic [CNT_W-1:0]                best_cnt_ff;
   logic                            rsp_valid_ff;
   logic [lltd_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic             accept, clear, commit;
   logic [NW-1:0]    active_n;
   logic [LW:0]      sum;
   logic [LW-1:0]    new_load;
   logic             cnt_sat;
   logic [CNT_W-1:0] slot, new_cnt;
   token_type        tok [MAX_WORKERS+1];
   token_type        last;
   update_type       upd;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign clear      = accept && req_tuser;
   assign commit     = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff <= lltd_pkg::WC_RESET;
      end else if (csr_wr_en) begin
         wc_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (wc_ff == '0) begin
         active_n = NW'(1);
      end else if (32'(wc_ff) > 32'(MAX_WORKERS)) begin
         active_n = NW'(MAX_WORKERS);
      end else begin
         active_n = NW'(wc_ff);
      end
   end

   // scan word injected at the head of the chain
   always_comb begin
      tok[0]       = '0;
      tok[0].valid = start_ff;
   end

   assign last = tok[MAX_WORKERS];

   for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
      lltd_cell #(
         .MAX_WORKERS (MAX_WORKERS),
         .MAX_TASKS   (MAX_TASKS),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .clear        (clear),
         .active_count (active_n),
         .tok_in       (tok[i]),
         .tok_out      (tok[i+1]),
         .upd          (upd)
      );
   end

   assign sum      = {1'b0, best_load_ff} + (LW+1)'(time_ff);
   assign new_load = sum[LW] ? '1 : sum[LW-1:0];
   assign cnt_sat  = best_cnt_ff >= CNT_W'(MAX_TASKS);
   assign slot     = cnt_sat ? CNT_W'(MAX_TASKS - 1) : best_cnt_ff;
   assign new_cnt  = cnt_sat ? best_cnt_ff : CNT_W'(best_cnt_ff + 1'b1);
   assign seen_in  = (seen_ff < CNT_W'(MAX_TASKS)) ? CNT_W'(seen_ff + 1'b1) : seen_ff;

   always_comb begin
      upd.en   = commit;
      upd.idx  = best_idx_ff;
      upd.load = new_load;
      upd.cnt  = new_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  time_ff  <= req_tdata[lltd_pkg::TIME_W-1:0];
                  start_ff <= 1'b1;
                  state_ff <= ST_SCAN;
                  if (req_tuser) begin
                     seen_ff <= '0;
                  end
               end
            end
            ST_SCAN: begin
               if (last.valid) begin
                  best_idx_ff  <= last.idx;
                  best_load_ff <= last.load;
                  best_cnt_ff  <= last.cnt;
                  state_ff     <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (commit) begin
                  seen_ff      <= seen_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {PAD_W'(0), new_load,
                                   lltd_pkg::SLOT_W'(slot),
                                   lltd_pkg::TASKNUM_W'(seen_in),
                                   lltd_pkg::WORKER_W'(best_idx_ff)};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_scan_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      last.valid |-> (state_ff == ST_SCAN))
      else $error("scan word left the chain outside of a scan");

   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      last.valid |-> last.found)
      else $error("scan finished without a chosen worker");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (start_ff && (state_ff == ST_SCAN)))
      else $error("accepted word did not start a scan");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("commit did not present a result");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(MAX_TASKS))
      else $error("task number beyond its limit");

endmodule

/* hdl/lltd_cell.sv */
// ----------------------------------------------------------------------------
// lltd_cell
// One worker: holds its load and task count, compares against the passing
// scan word and forwards the running minimum to the next cell.
// ----------------------------------------------------------------------------
module lltd_cell #(
   parameter int MAX_WORKERS = lltd_pkg::DEF_MAX_WORKERS,
   parameter int MAX_TASKS   = lltd_pkg::DEF_MAX_TASKS,
   parameter int INDEX       = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  logic [$clog2(MAX_WORKERS+1)-1:0] active_count,
   input  logic [1+1+((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)
                 +lltd_pkg::LOAD_W+$clog2(MAX_TASKS+1)-1:0] tok_in,
   output logic [1+1+((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)
                 +lltd_pkg::LOAD_W+$clog2(MAX_TASKS+1)-1:0] tok_out,
   input  logic [1+((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)
                 +lltd_pkg::LOAD_W+$clog2(MAX_TASKS+1)-1:0] upd
);

   localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int NW    = $clog2(MAX_WORKERS + 1);

   typedef struct packed {
      logic                        valid;
      logic                        found;
      logic [IDX_W-1:0]            idx;
      logic [lltd_pkg::LOAD_W-1:0] load;
      logic [CNT_W-1:0]            cnt;
   } token_type;

   typedef struct packed {
      logic                        en;
      logic [IDX_W-1:0]            idx;
      logic [lltd_pkg::LOAD_W-1:0] load;
      logic [CNT_W-1:0]            cnt;
   } update_type;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   token_type                   tin;
   token_type                   tok_ff, tok_in_nxt;
   update_type                  u;
   logic [lltd_pkg::LOAD_W-1:0] load_ff, load_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        active, take;

   assign tin     = token_type'(tok_in);
   assign u       = update_type'(upd);
   assign tok_out = tok_ff;

   assign active = NW'(INDEX) < active_count;
   assign take   = tin.valid && active && (!tin.found || (load_ff < tin.load));

   always_comb begin
      tok_in_nxt = tin;
      if (take) begin
         tok_in_nxt.found = 1'b1;
         tok_in_nxt.idx   = MY_IDX;
         tok_in_nxt.load  = load_ff;
         tok_in_nxt.cnt   = cnt_ff;
      end
   end

   always_comb begin
      load_in = load_ff;
      cnt_in  = cnt_ff;
      if (clear) begin
         load_in = '0;
         cnt_in  = '0;
      end else if (u.en && (u.idx == MY_IDX)) begin
         load_in = u.load;
         cnt_in  = u.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         load_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         tok_ff  <= tok_in_nxt;
         load_ff <= load_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
